[src/sha256_pkg.sv]
`timescale 1ns / 1ps

package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

[src/sha256_message_digest.sv]
`timescale 1ns / 1ps

// SHA-256 over a byte stream: at most one message byte per request, packed big-endian
// into a 64-byte block. The byte that fills a block starts a compression by the single
// round unit, which runs the 64 rounds one per cycle and then one chaining update. A
// request with last set then adds a padding step and one or two compressions (64 rounds
// and one chaining update each), and then presents the eight digest words, most
// significant first, one per accepted result. s_ready is low while padding, while a
// block compresses or while digest words are pending; the state then returns to the
// initial hash value.
module sha256_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha256_pkg::*;

    state_t       state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  blk_reg [16];
    logic [31:0]  v_reg [8];
    logic [63:0]  count_reg;
    logic [5:0]   round_reg;
    logic         fin_reg;
    logic         second_reg;
    logic         padded_reg;
    logic [2:0]   out_idx_reg;

    logic         accept;
    logic [5:0]   pos;
    logic [3:0]   wi;
    logic [31:0]  w, s0, s1, t1, t2, ws0, ws1;
    logic [63:0]  bits;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_digest_word = h_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);
    assign pos  = count_reg[5:0];
    assign wi   = pos[5:2];
    assign bits = {count_reg[60:0], 3'b000};

    // The block store doubles as the rolling schedule ring.
    always_comb begin
        ws0 = {blk_reg[1][6:0], blk_reg[1][31:7]} ^ {blk_reg[1][17:0], blk_reg[1][31:18]}
            ^ (blk_reg[1] >> 3);
        ws1 = {blk_reg[14][16:0], blk_reg[14][31:17]}
            ^ {blk_reg[14][18:0], blk_reg[14][31:19]} ^ (blk_reg[14] >> 10);
        w   = blk_reg[0];
        s1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
            ^ {v_reg[4][24:0], v_reg[4][31:25]};
        t1  = v_reg[7] + s1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + ROUND_K[round_reg] + w;
        s0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
            ^ {v_reg[0][21:0], v_reg[0][31:22]};
        t2  = s0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_has_byte && pos == 6'd63) begin
                        state_next = ST_ROUND;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:    state_next = ST_ROUND;
            ST_ROUND:  state_next = (round_reg == 6'd63) ? ST_UPDATE : ST_ROUND;
            ST_UPDATE: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (!padded_reg) begin
                    state_next = ST_PAD;
                end else if (second_reg) begin
                    state_next = ST_ROUND;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready && out_idx_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_H[i];
            end
            count_reg   <= '0;
            round_reg   <= '0;
            fin_reg     <= 1'b0;
            second_reg  <= 1'b0;
            padded_reg  <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= h_reg[i];
                    end
                    round_reg <= '0;
                    if (accept) begin
                        fin_reg <= s_last;
                        if (s_has_byte) begin
                            case (pos[1:0])
                                2'd0:    blk_reg[wi] <= {s_data_byte, 24'd0};
                                2'd1:    blk_reg[wi][23:16] <= s_data_byte;
                                2'd2:    blk_reg[wi][15:8] <= s_data_byte;
                                default: blk_reg[wi][7:0] <= s_data_byte;
                            endcase
                            count_reg <= count_reg + 64'd1;
                        end
                    end
                end
                ST_PAD: begin
                    for (int i = 0; i < 16; i++) begin
                        if (i[3:0] > wi && (i < 14 || pos >= 6'd56)) begin
                            blk_reg[i] <= '0;
                        end
                    end
                    case (pos[1:0])
                        2'd0:    blk_reg[wi] <= {PAD_BYTE, 24'd0};
                        2'd1:    blk_reg[wi][23:16] <= PAD_BYTE;
                        2'd2:    blk_reg[wi][15:8] <= PAD_BYTE;
                        default: blk_reg[wi][7:0] <= PAD_BYTE;
                    endcase
                    if (pos < 6'd56) begin
                        blk_reg[14] <= bits[63:32];
                        blk_reg[15] <= bits[31:0];
                        second_reg  <= 1'b0;
                    end else begin
                        second_reg  <= 1'b1;
                    end
                    padded_reg <= 1'b1;
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= h_reg[i];
                    end
                    round_reg <= '0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        blk_reg[i] <= blk_reg[i + 1];
                    end
                    blk_reg[15] <= ws1 + blk_reg[9] + ws0 + blk_reg[0];
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                end
                ST_UPDATE: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                        v_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    round_reg <= '0;
                    out_idx_reg <= '0;
                    if (second_reg) begin
                        for (int i = 0; i < 14; i++) begin
                            blk_reg[i] <= '0;
                        end
                        blk_reg[14] <= bits[63:32];
                        blk_reg[15] <= bits[31:0];
                        second_reg  <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= INIT_H[i];
                            end
                            count_reg  <= '0;
                            fin_reg    <= 1'b0;
                            padded_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                    round_reg <= '0;
                end
            endcase
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    sha256_message_digest dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_has_byte(s_has_byte), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_digest_word(m_digest_word),
        .m_word_index(m_word_index), .m_last_word(m_last_word)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    byte_req_t   pending_reqs[$];
    digest_res_t expected_words[$];
    int          send_idle_pct = 24;
    int          recv_idle_pct = 70;
    int          hold_off = 0;
    bit          pause_send = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          timed_out = 0;

    logic [31:0] hash_state[8];
    logic [31:0] msg_block[16];
    logic [63:0] msg_bytes;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w[t] = msg_block[t];
            end else begin
                w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                    + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            end
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                + ROUND_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        msg_bytes = '0;
    endtask

    task automatic place_byte(int pos, logic [7:0] b);
        if (pos % 4 == 0) msg_block[pos / 4] = {b, 24'h0};
        else msg_block[pos / 4] |= 32'(b) << (24 - 8 * (pos % 4));
    endtask

    task automatic absorb_request(byte_req_t r);
        int pos;
        logic [63:0] bit_len;
        if (r.has_byte) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, r.data_byte);
            msg_bytes++;
            if (pos == 63) compress();
        end
        if (r.last) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, PAD_BYTE);
            for (int i = pos / 4 + 1; i < 16; i++) msg_block[i] = '0;
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) msg_block[i] = '0;
            end
            bit_len = msg_bytes << 3;
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress();
            for (int i = 0; i < 8; i++)
                expected_words.push_back({hash_state[i], 3'(i), i == 7});
            clear_hash();
        end
    endtask

    task automatic queue_message(int len, int kind);
        byte_req_t r;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                pending_reqs.push_back({8'($urandom), 1'b0, 1'b0});
            case (kind)
                0: r.data_byte = 8'($urandom);
                1: r.data_byte = 8'hff;
                default: r.data_byte = 8'h00;
            endcase
            r.has_byte = 1'b1;
            r.last = (i == len - 1);
            pending_reqs.push_back(r);
        end
        if (len == 0) pending_reqs.push_back({8'($urandom), 1'b0, 1'b1});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) absorb_request({s_data_byte, s_has_byte, s_last});
            if (pending_reqs.size() > 0 && !pause_send
                && $urandom_range(0, 99) >= send_idle_pct) begin
                byte_req_t r;
                r = pending_reqs.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= r.data_byte;
                s_has_byte  <= r.has_byte;
                s_last      <= r.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_digest_word);
            end else begin
                digest_res_t e;
                e = expected_words.pop_front();
                if (e != {m_digest_word, m_word_index, m_last_word}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                            e.digest_word, e.word_index, e.last_word,
                            m_digest_word, m_word_index, m_last_word);
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        clear_hash();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        pending_reqs.push_back({8'h00, 1'b0, 1'b0});
        queue_message(0, 0);
        queue_message(3, 0);
        queue_message(1, 1);
        queue_message(1, 2);
        pending_reqs.push_back({8'h5a, 1'b1, 1'b0});
        pending_reqs.push_back({8'hff, 1'b0, 1'b1});
        queue_message(5, 1);
        wait_drained();
        queue_message(55, 0);
        queue_message(56, 0);
        queue_message(64, 2);
        wait_drained();
        queue_message(40, 0);
        hold_off = 400;
        wait_drained();
        pause_send = 1;
        repeat (20) @(posedge aclk);
        pause_send = 0;
        for (int k = 0; k < 3; k++) queue_message($urandom_range(0, 63), $urandom_range(0, 3));
        wait_drained();
        send_idle_pct = 70; recv_idle_pct = 24;
        for (int k = 0; k < 4; k++) queue_message($urandom_range(0, 20), 0);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        queue_message(1, 0);
        queue_message($urandom_range(60, 70), 0);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[filelist.f]
src/sha256_pkg.sv
src/sha256_message_digest.sv
tb/sv/tb.sv
